[hdl/apsfr_pkg.sv]
// ----------------------------------------------------------------------------
// apsfr_pkg
// Shared constants, types and the FCS-16 byte update for the PPP/SLIP
// frame receiver.
// ----------------------------------------------------------------------------
package apsfr_pkg;

    localparam int unsigned LENGTH_BITS_DEFAULT = 14;
    // 1500 payload + 2 address/control + 50 slack + 2 FCS
    localparam int unsigned MAX_STORED_DEFAULT  = 1554;
    localparam int unsigned CFG_INDEX_BITS      = 1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAMING_MODE = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_STORED   = 1'd1;

    localparam logic [7:0] PPP_FLAG       = 8'h7E;
    localparam logic [7:0] PPP_ESC        = 8'h7D;
    localparam logic [7:0] PPP_XOR        = 8'h20;
    localparam logic [7:0] SLIP_FEND      = 8'hC0;
    localparam logic [7:0] SLIP_FESC      = 8'hDB;
    localparam logic [7:0] SLIP_TFEND     = 8'hDC;
    localparam logic [7:0] SLIP_TFESC     = 8'hDD;

    localparam logic [15:0] FCS_INIT = 16'hFFFF;
    localparam logic [15:0] FCS_POLY = 16'h8408;

    typedef enum logic [1:0] {
        ST_GOOD      = 2'd0,
        ST_CRC_ERROR = 2'd1,
        ST_SHORT     = 2'd2,
        ST_TOO_LONG  = 2'd3
    } t_status;

    // reflected CRC-16/X.25, one byte, LSB first
    function automatic logic [15:0] fcs16_byte(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hdl/apsfr_fcs16.sv]
// ----------------------------------------------------------------------------
// apsfr_fcs16
// Byte-wide FCS-16 update with a load-enable and frame restart.
// ----------------------------------------------------------------------------
module apsfr_fcs16 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_restart,
    input  logic        i_update,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_fcs
);
    import apsfr_pkg::*;

    logic [15:0] r_fcs;
    logic [15:0] n_fcs;

    always_comb begin
        n_fcs = r_fcs;
        if (i_restart) begin
            n_fcs = FCS_INIT;
        end else if (i_update) begin
            n_fcs = fcs16_byte(r_fcs, i_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcs <= FCS_INIT;
        end else begin
            r_fcs <= n_fcs;
        end
    end

    assign o_fcs = r_fcs;

endmodule

[hdl/async_ppp_slip_frame_receiver.sv]
// ----------------------------------------------------------------------------
// async_ppp_slip_frame_receiver
// Strips PPP async HDLC or SLIP framing from line bytes; in PPP mode holds back
// the FCS and checks it. Reports frame status on an end-marker item.
// ----------------------------------------------------------------------------
// Output: a result item reaches the output register in the cycle after the
// line byte that causes it is accepted. Throughput: one line byte per cycle
// while the output register is empty or taken; the output register accepts
// a new result in the cycle its previous one is taken.
// Reset: synchronous, active low; receiver returns to hunting for a flag,
// PPP mode and the default length limit.
// ----------------------------------------------------------------------------
module async_ppp_slip_frame_receiver #(
    parameter int unsigned LENGTH_BITS = apsfr_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config
    input  logic                                i_cfg_we,
    input  logic [apsfr_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [LENGTH_BITS-1:0]              i_cfg_data,
    // line bytes
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [7:0]                          i_rx_byte,
    // results
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [7:0]                          o_data_byte,
    output logic                                o_frame_end,
    output logic [1:0]                          o_frame_status
);
    import apsfr_pkg::*;

    localparam logic [LENGTH_BITS-1:0] MAX_RESET =
        LENGTH_BITS'(MAX_STORED_DEFAULT % (1 << LENGTH_BITS));

    logic                   r_slip;
    logic [LENGTH_BITS-1:0] r_max;
    logic                   r_hunting, n_hunting;
    logic                   r_esc, n_esc;
    logic                   r_overlong, n_overlong;
    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic [7:0]             r_tail0, n_tail0;
    logic [7:0]             r_tail1, n_tail1;

    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_out_data;
    logic                   r_out_end;
    t_status                r_out_status;

    logic                   accept;
    logic [7:0]             flag_b, esc_b, ub;
    logic [15:0]            fcs;
    logic                   fcs_restart, fcs_update;
    logic [7:0]             fcs_byte;
    logic                   res_valid, res_end;
    logic [7:0]             res_data;
    t_status                res_status;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    assign flag_b = r_slip ? SLIP_FEND : PPP_FLAG;
    assign esc_b  = r_slip ? SLIP_FESC : PPP_ESC;

    // unescaped byte
    always_comb begin
        ub = i_rx_byte;
        if (r_esc) begin
            if (!r_slip) begin
                ub = i_rx_byte ^ PPP_XOR;
            end else if (i_rx_byte == SLIP_TFESC) begin
                ub = SLIP_FESC;
            end else if (i_rx_byte == SLIP_TFEND) begin
                ub = SLIP_FEND;
            end
        end
    end

    always_comb begin
        n_hunting   = r_hunting;
        n_esc       = r_esc;
        n_overlong  = r_overlong;
        n_count     = r_count;
        n_tail0     = r_tail0;
        n_tail1     = r_tail1;
        fcs_restart = 1'b0;
        fcs_update  = 1'b0;
        fcs_byte    = r_slip ? ub : r_tail0;
        res_valid   = 1'b0;
        res_end     = 1'b0;
        res_data    = 8'h00;
        res_status  = ST_GOOD;
        if (accept) begin
            priority if (i_rx_byte == flag_b) begin
                if (!r_hunting && (r_count != '0 || r_overlong)) begin
                    res_valid = 1'b1;
                    res_end   = 1'b1;
                    priority if (r_overlong) begin
                        res_status = ST_TOO_LONG;
                    end else if (r_slip) begin
                        res_status = ST_GOOD;
                    end else if (r_count < LENGTH_BITS'(3)) begin
                        res_status = ST_SHORT;
                    end else if ({r_tail1, r_tail0} == ~fcs) begin
                        res_status = ST_GOOD;
                    end else begin
                        res_status = ST_CRC_ERROR;
                    end
                end
                n_hunting   = 1'b0;
                n_esc       = 1'b0;
                n_overlong  = 1'b0;
                n_count     = '0;
                n_tail0     = 8'h00;
                n_tail1     = 8'h00;
                fcs_restart = 1'b1;
            end else if (r_hunting) begin
                // dropped until first flag
            end else if (i_rx_byte == esc_b) begin
                n_esc = 1'b1;
            end else if (r_overlong) begin
                // discard rest of frame
            end else if (r_count >= r_max) begin
                n_overlong = 1'b1;
            end else begin
                n_esc   = 1'b0;
                n_count = r_count + LENGTH_BITS'(1);
                if (r_slip) begin
                    fcs_update = 1'b1;
                    res_valid  = 1'b1;
                    res_data   = ub;
                end else begin
                    // two-byte hold-back keeps the FCS from being released
                    if (r_count >= LENGTH_BITS'(2)) begin
                        fcs_update = 1'b1;
                        res_valid  = 1'b1;
                        res_data   = r_tail0;
                    end
                    n_tail0 = r_tail1;
                    n_tail1 = ub;
                end
            end
        end
    end

    assign n_out_valid = (accept && res_valid) || (r_out_valid && !i_ready);

    apsfr_fcs16 u_fcs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (fcs_restart),
        .i_update  (fcs_update),
        .i_byte    (fcs_byte),
        .o_fcs     (fcs)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slip <= 1'b0;
            r_max  <= MAX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAMING_MODE: r_slip <= i_cfg_data[0];
                CFG_MAX_STORED:   r_max  <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting   <= 1'b1;
            r_esc       <= 1'b0;
            r_overlong  <= 1'b0;
            r_count     <= '0;
            r_tail0     <= 8'h00;
            r_tail1     <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            r_hunting   <= n_hunting;
            r_esc       <= n_esc;
            r_overlong  <= n_overlong;
            r_count     <= n_count;
            r_tail0     <= n_tail0;
            r_tail1     <= n_tail1;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_out_data   <= res_data;
            r_out_end    <= res_end;
            r_out_status <= res_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_data_byte    = r_out_data;
    assign o_frame_end    = r_out_end;
    assign o_frame_status = r_out_status;

endmodule
